@@ hdl/sbm_pkg.sv @@
// Package for the strided block matrix-vector accumulate core.
// Holds shared widths, register and action codes, the pipeline tag type and
// the saturating add. No dependencies.
`default_nettype none

package sbm_pkg;

   localparam int ROW_WIDTH_W = 7;
   localparam int ROW_W       = 16;
   localparam int X_INDEX_W   = 6;
   localparam int VAL_W       = 32;
   localparam int ACC_W       = 64;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic {
      ACT_LOAD   = 1'b0,
      ACT_MATRIX = 1'b1
   } sbm_action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_WIDTH = 2'd0,
      CSR_FIRST_ROW = 2'd1,
      CSR_END_ROW   = 2'd2,
      CSR_UNUSED    = 2'd3
   } sbm_csr_type;

   // Per-item control decided when a matrix word is accepted.
   typedef struct packed {
      logic             first;
      logic             last;
      logic             emit;
      logic [ROW_W-1:0] row_index;
   } sbm_tag_type;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b
   );
      logic signed [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         return s[ACC_W] ? ACC_MIN : ACC_MAX;
      end
      return s[ACC_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ hdl/sbm_channels.sv @@
// Valid/ready channel interfaces for request and response words.
// Depends on sbm_pkg for field widths.
`default_nettype none

interface sbm_req_if import sbm_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [X_INDEX_W-1:0]        x_index;
   logic signed [VAL_W-1:0]     x_value;
   logic signed [VAL_W-1:0]     a_value;
   logic signed [ACC_W-1:0]     y_in;

   modport source (output valid, action, x_index, x_value, a_value, y_in, input ready);
   modport sink (input valid, action, x_index, x_value, a_value, y_in, output ready);
endinterface

interface sbm_rsp_if import sbm_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [ROW_W-1:0]            row_index;
   logic signed [ACC_W-1:0]     y_out;

   modport source (output valid, row_index, y_out, input ready);
   modport sink (input valid, row_index, y_out, output ready);
endinterface

`default_nettype wire

@@ hdl/strided_block_matvec_accumulate_core.sv @@
// Top level of the strided block matrix-vector accumulate core.
// Depends on sbm_pkg, sbm_channels, sbm_ctrl, sbm_vstore and sbm_datapath.
//
// The core takes one request word per clock while req ready is high: a load
// word writes a vector element into the on-chip store and restarts the
// strip at first_row; a matrix word is multiplied by the stored element of
// its column and added into the row sum, and the row's last word returns
// y_in plus the row sum, saturated, as one response word (rows at or past
// end_row return nothing). rsp valid rises when the row's last word reaches
// the output register; the accumulator and the registered store read keep that
// rate. A waiting response holds only the last stage: words that end no
// reported row still pass on behind it, and once the next reported row end
// has reached the stage in front of it, as many matrix words as the operand
// and product stages have room for, at most two, are taken before req ready
// falls. Write the csr registers only while the core is idle.
`default_nettype none

module strided_block_matvec_accumulate_core import sbm_pkg::*; #(
   parameter int MAX_WIDTH = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   sbm_req_if.sink                    req_bus,
   sbm_rsp_if.source                  rsp_bus,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic                    ready;
   logic                    fire;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [AW-1:0]           rd_addr;
   logic signed [VAL_W-1:0] x_rd;
   sbm_tag_type             tag;

   assign req_bus.ready = ready;
   assign fire = req_bus.valid && ready;

   sbm_ctrl #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_fire    (fire),
      .req_action  (req_bus.action),
      .req_x_index (req_bus.x_index),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .rd_addr     (rd_addr),
      .tag         (tag)
   );

   sbm_vstore #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW)
   ) u_vstore (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_bus.x_value),
      .rd_en   (ready),
      .rd_addr (rd_addr),
      .rd_data (x_rd)
   );

   sbm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .in_matrix  (fire && (req_bus.action == ACT_MATRIX)),
      .in_ready   (ready),
      .in_tag     (tag),
      .in_a_value (req_bus.a_value),
      .in_y_in    (req_bus.y_in),
      .x_rd       (x_rd),
      .rsp        (rsp_bus)
   );

endmodule

`default_nettype wire

@@ hdl/sbm_ctrl.sv @@
// Configuration registers and strip sequencing: column and row counters,
// store addresses and the per-word tag. Depends on sbm_pkg.
`default_nettype none

module sbm_ctrl import sbm_pkg::*; #(
   parameter int MAX_WIDTH = 64,
   parameter int AW        = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_fire,
   input  wire logic                  req_action,
   input  wire logic [X_INDEX_W-1:0]  req_x_index,
   output logic                       wr_en,
   output logic [AW-1:0]              wr_addr,
   output logic [AW-1:0]              rd_addr,
   output sbm_tag_type                tag
);

   logic [ROW_WIDTH_W-1:0] row_width_ff, row_width_in;
   logic [ROW_W-1:0]       first_row_ff, first_row_in;
   logic [ROW_W-1:0]       end_row_ff, end_row_in;
   logic [ROW_WIDTH_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0]       row_count_ff, row_count_in;

   logic [ROW_WIDTH_W-1:0] width_eff;
   logic [ROW_WIDTH_W:0]   col_next;
   logic [ROW_W:0]         row_full;
   logic                   is_last;
   logic                   fire_load;
   logic                   fire_matrix;

   assign fire_load   = req_fire && (req_action == ACT_LOAD);
   assign fire_matrix = req_fire && (req_action == ACT_MATRIX);

   always_comb begin
      if (row_width_ff == '0) begin
         width_eff = ROW_WIDTH_W'(1);
      end else if (32'(row_width_ff) > MAX_WIDTH) begin
         width_eff = ROW_WIDTH_W'(MAX_WIDTH);
      end else begin
         width_eff = row_width_ff;
      end
   end

   // A column at or past a lowered width also closes the row.
   assign col_next = {1'b0, col_ff} + (ROW_WIDTH_W+1)'(1);
   assign is_last  = col_next >= {1'b0, width_eff};
   assign row_full = {1'b0, first_row_ff} + {1'b0, row_count_ff};

   assign tag.first     = (col_ff == '0);
   assign tag.last      = is_last;
   assign tag.emit      = row_full < {1'b0, end_row_ff};
   assign tag.row_index = row_full[ROW_W-1:0];

   assign rd_addr = AW'(col_ff);
   assign wr_addr = AW'(req_x_index);
   assign wr_en   = fire_load && (32'(req_x_index) < MAX_WIDTH);

   always_comb begin
      row_width_in = row_width_ff;
      first_row_in = first_row_ff;
      end_row_in   = end_row_ff;
      if (csr_we) begin
         case (sbm_csr_type'(csr_index))
            CSR_ROW_WIDTH: row_width_in = csr_wdata[ROW_WIDTH_W-1:0];
            CSR_FIRST_ROW: first_row_in = csr_wdata;
            CSR_END_ROW:   end_row_in   = csr_wdata;
            default:       row_width_in = row_width_ff;
         endcase
      end
   end

   always_comb begin
      col_in       = col_ff;
      row_count_in = row_count_ff;
      if (fire_load) begin
         col_in       = '0;
         row_count_in = '0;
      end else if (fire_matrix) begin
         if (is_last) begin
            col_in = '0;
            if (row_count_ff != {ROW_W{1'b1}}) begin
               row_count_in = row_count_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_next[ROW_WIDTH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_W'(1);
         first_row_ff <= '0;
         end_row_ff   <= '0;
         col_ff       <= '0;
         row_count_ff <= '0;
      end else begin
         row_width_ff <= row_width_in;
         first_row_ff <= first_row_in;
         end_row_ff   <= end_row_in;
         col_ff       <= col_in;
         row_count_ff <= row_count_in;
      end
   end

   a_load_restarts: assert property (@(posedge clock) disable iff (reset)
      fire_load |=> (col_ff == '0) && (row_count_ff == '0))
      else $error("load word did not restart the strip");

   a_col_steps: assert property (@(posedge clock) disable iff (reset)
      (fire_matrix && !is_last) |=> (col_ff == $past(col_next[ROW_WIDTH_W-1:0])))
      else $error("column position did not advance by one");

   a_row_count_holds: assert property (@(posedge clock) disable iff (reset)
      ((row_count_ff == {ROW_W{1'b1}}) && !fire_load) |=> (row_count_ff == {ROW_W{1'b1}}))
      else $error("saturated row count moved");

endmodule

`default_nettype wire

@@ hdl/sbm_vstore.sv @@
// Vector element store: one write port, one read port, registered read data.
// Depends on sbm_pkg for the element width.
`default_nettype none

module sbm_vstore import sbm_pkg::*; #(
   parameter int MAX_WIDTH = 64,
   parameter int AW        = 6
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [AW-1:0]           wr_addr,
   input  wire logic signed [VAL_W-1:0] wr_data,
   input  wire logic                    rd_en,
   input  wire logic [AW-1:0]           rd_addr,
   output logic signed [VAL_W-1:0]      rd_data
);

   logic signed [VAL_W-1:0] mem [MAX_WIDTH];
   logic signed [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/sbm_datapath.sv @@
// Multiply-accumulate pipeline: operand stage, product stage, row sum
// accumulator and saturating output register. Depends on sbm_pkg and the
// response channel interface.
`default_nettype none

module sbm_datapath import sbm_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_matrix,
   output logic                         in_ready,
   input  wire sbm_tag_type             in_tag,
   input  wire logic signed [VAL_W-1:0] in_a_value,
   input  wire logic signed [ACC_W-1:0] in_y_in,
   input  wire logic signed [VAL_W-1:0] x_rd,
   sbm_rsp_if.source                    rsp
);

   logic                    v1_ff, v2_ff, v3_ff, v4_ff;
   logic                    en1, en2, en3, en4;
   sbm_tag_type             tag1_ff, tag2_ff;
   logic signed [VAL_W-1:0] a1_ff;
   logic signed [ACC_W-1:0] y1_ff, y2_ff, y3_ff, y4_ff;
   logic signed [ACC_W-1:0] prod_c, prod2_ff;
   logic signed [ACC_W-1:0] sum_ff, sum_in;
   logic [ROW_W-1:0]        row3_ff, row4_ff;

   // Each stage loads when it is empty or its successor moves on.
   assign en4 = !v4_ff || rsp.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign in_ready = en1;

   assign prod_c = a1_ff * x_rd;
   assign sum_in = sat_add(tag2_ff.first ? '0 : sum_ff, prod2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         sum_ff <= '0;
      end else begin
         if (en1) begin
            v1_ff <= in_matrix;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff && tag2_ff.last && tag2_ff.emit;
            if (v2_ff) begin
               sum_ff <= sum_in;
            end
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         tag1_ff <= in_tag;
         a1_ff   <= in_a_value;
         y1_ff   <= in_y_in;
      end
      if (en2) begin
         tag2_ff  <= tag1_ff;
         prod2_ff <= prod_c;
         y2_ff    <= y1_ff;
      end
      if (en3) begin
         row3_ff <= tag2_ff.row_index;
         y3_ff   <= y2_ff;
      end
      if (en4) begin
         row4_ff <= row3_ff;
         y4_ff   <= sat_add(y3_ff, sum_ff);
      end
   end

   assign rsp.valid     = v4_ff;
   assign rsp.row_index = row4_ff;
   assign rsp.y_out     = y4_ff;

   a_result_from_row_end: assert property (@(posedge clock) disable iff (reset)
      $rose(v4_ff) |-> $past(v3_ff))
      else $error("result appeared without a finished row behind it");

   a_sum_frozen_on_stall: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !en4) |=> $stable(sum_ff))
      else $error("row sum changed while its row end was stalled");

   a_operand_held: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !en2) |=> $stable(x_rd))
      else $error("store read data changed under a stalled operand stage");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for strided_block_matvec_accumulate_core.
// A queue-fed driver streams load and matrix words, a clocked monitor checks every response word
// against an in-bench row accumulator. Depends on sbm_pkg, sbm_channels and the core.
`default_nettype none

module tb_top;
   import sbm_pkg::*;

   localparam int          STORE_DEPTH  = 64;
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned QUIET_LIMIT  = 1000;
   localparam int unsigned HOLD_CYCLES  = 60;

   localparam logic signed [VAL_W-1:0] Q16_MIN = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] Q16_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      sbm_action_type          action;
      logic [X_INDEX_W-1:0]    x_index;
      logic signed [VAL_W-1:0] x_value;
      logic signed [VAL_W-1:0] a_value;
      logic signed [ACC_W-1:0] y_in;
   } mac_word_type;

   typedef struct packed {
      logic [ROW_W-1:0]        row_index;
      logic signed [ACC_W-1:0] y_out;
   } row_result_type;

   logic clock;
   logic reset;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ROW_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   sbm_req_if req_if ();
   sbm_rsp_if rsp_if ();

   strided_block_matvec_accumulate_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Words waiting to go out and row results the core still owes us.
   mac_word_type   words_to_send [$];
   row_result_type row_results_due [$];
   mac_word_type   word_on_bus;
   row_result_type due;

   int unsigned words_pushed  = 0;
   int unsigned words_taken   = 0;
   int unsigned fail_count    = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_left     = 0;
   logic        hold_armed    = 1'b0;
   logic        hold_done     = 1'b0;

   // Shadow of the core: register copies and accumulator state.
   logic [ROW_WIDTH_W-1:0]  cfg_width = 7'd1;
   logic [ROW_W-1:0]        cfg_first = '0;
   logic [ROW_W-1:0]        cfg_end   = '0;
   logic signed [VAL_W-1:0] vec_mem [STORE_DEPTH];
   logic signed [ACC_W-1:0] dot_acc  = '0;
   logic [ROW_WIDTH_W-1:0]  col_pos  = '0;
   logic [ROW_W-1:0]        rows_done = '0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned eff_width(input logic [ROW_WIDTH_W-1:0] w);
      if (w == 0) return 1;
      if (w > STORE_DEPTH) return STORE_DEPTH;
      return 32'(w);
   endfunction

   function automatic logic signed [ACC_W-1:0] clamp_add(
      input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b
   );
      logic signed [ACC_W-1:0] s;
      s = a + b;
      // Overflow only when both operands share a sign that the sum lost.
      if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
         s = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
      end
      return s;
   endfunction

   task automatic accumulate_word(input mac_word_type w);
      int unsigned             width;
      logic signed [ACC_W-1:0] prod;
      logic [ROW_W:0]          row;
      row_result_type          r;
      if (w.action == ACT_LOAD) begin
         vec_mem[w.x_index] = w.x_value;
         rows_done = '0;
         col_pos   = '0;
         dot_acc   = '0;
      end else begin
         width   = eff_width(cfg_width);
         prod    = longint'($signed(w.a_value)) * longint'($signed(vec_mem[col_pos[5:0]]));
         dot_acc = clamp_add(dot_acc, prod);
         if (col_pos + 1 < width) begin
            col_pos = col_pos + 1'b1;
         end else begin
            row = {1'b0, cfg_first} + {1'b0, rows_done};
            if (row < {1'b0, cfg_end}) begin
               r.row_index = row[ROW_W-1:0];
               r.y_out     = clamp_add(w.y_in, dot_acc);
               row_results_due.push_back(r);
            end
            dot_acc = '0;
            col_pos = '0;
            if (rows_done != 16'hFFFF) rows_done = rows_done + 1'b1;
         end
      end
   endtask

   function automatic logic signed [VAL_W-1:0] pick_q16();
      case ($urandom_range(0, 9))
         0: return Q16_MIN;
         1: return Q16_MAX;
         2: return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [ACC_W-1:0] pick_q32();
      case ($urandom_range(0, 9))
         0: return ACC_MIN;
         1: return ACC_MAX;
         2: return '0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic queue_load(input logic [X_INDEX_W-1:0] idx, input logic signed [VAL_W-1:0] val);
      mac_word_type w;
      w.action  = ACT_LOAD;
      w.x_index = idx;
      w.x_value = val;
      w.a_value = $urandom;
      w.y_in    = {$urandom, $urandom};
      words_to_send.push_back(w);
      words_pushed++;
   endtask

   task automatic queue_matrix(input logic signed [VAL_W-1:0] a, input logic signed [ACC_W-1:0] y);
      mac_word_type w;
      w.action  = ACT_MATRIX;
      w.x_index = X_INDEX_W'($urandom_range(0, STORE_DEPTH - 1));
      w.x_value = $urandom;
      w.a_value = a;
      w.y_in    = y;
      words_to_send.push_back(w);
      words_pushed++;
   endtask

   // Mostly whole rows; some loads and some rows cut short by a load.
   task automatic queue_random_words(input int unsigned count, input int unsigned width);
      int unsigned made;
      int unsigned roll;
      int unsigned part;
      made = 0;
      while (made < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 80) begin
            repeat (width) queue_matrix(pick_q16(), pick_q32());
            made += width;
         end else if (roll < 92) begin
            queue_load(X_INDEX_W'($urandom_range(0, STORE_DEPTH - 1)), pick_q16());
            made++;
         end else begin
            part = (width > 1) ? $urandom_range(1, width - 1) : 0;
            repeat (part) queue_matrix(pick_q16(), pick_q32());
            queue_load(X_INDEX_W'($urandom_range(0, STORE_DEPTH - 1)), pick_q16());
            made += part + 1;
         end
      end
   endtask

   task automatic write_csrs(
      input logic [ROW_WIDTH_W-1:0] w,
      input logic [ROW_W-1:0]       f,
      input logic [ROW_W-1:0]       e
   );
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_ROW_WIDTH;
      csr_wdata <= {9'($urandom), w};
      @(posedge clock);
      csr_index <= CSR_FIRST_ROW;
      csr_wdata <= f;
      @(posedge clock);
      csr_index <= CSR_END_ROW;
      csr_wdata <= e;
      @(posedge clock);
      csr_index <= CSR_UNUSED;
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_width = w;
      cfg_first = f;
      cfg_end   = e;
      @(negedge clock);
   endtask

   // Wait until every word is taken and every row result has come back,
   // then let the pipeline empty of words that produce nothing.
   task automatic wait_idle();
      while (words_taken != words_pushed || row_results_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.action  <= ACT_LOAD;
         req_if.x_index <= '0;
         req_if.x_value <= '0;
         req_if.a_value <= '0;
         req_if.y_in    <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            accumulate_word(word_on_bus);
            words_taken++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               word_on_bus = words_to_send.pop_front();
               req_if.valid   <= 1'b1;
               req_if.action  <= word_on_bus.action;
               req_if.x_index <= word_on_bus.x_index;
               req_if.x_value <= word_on_bus.x_value;
               req_if.a_value <= word_on_bus.a_value;
               req_if.y_in    <= word_on_bus.y_in;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (row_results_due.size() == 0) begin
               $error("unexpected response word: row_index %0d, y_out %0d",
                      rsp_if.row_index, rsp_if.y_out);
               fail_count++;
            end else begin
               due = row_results_due.pop_front();
               if (rsp_if.row_index !== due.row_index) begin
                  $error("row_index mismatch: expected %0d, actual %0d",
                         due.row_index, rsp_if.row_index);
                  fail_count++;
               end
               if (rsp_if.y_out !== due.y_out) begin
                  $error("y_out mismatch: expected %0d, actual %0d",
                         $signed(due.y_out), rsp_if.y_out);
                  fail_count++;
               end
            end
         end
         // One long hold-off lets the core fill up and push back on its input.
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned w;
      int unsigned f;
      int unsigned e;
      int unsigned k;
      int unsigned mode;
      int unsigned sub;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Fill the whole store first so no matrix word ever reads an unwritten entry.
      write_csrs(7'd4, 16'd10, 16'd1000);
      for (k = 0; k < STORE_DEPTH; k++) queue_load(k[5:0], pick_q16());

      // Extreme operands: sums that saturate high and low, prior values at the rails.
      queue_load(6'd0, Q16_MIN);
      queue_load(6'd1, Q16_MIN);
      queue_load(6'd2, Q16_MAX);
      queue_load(6'd3, 32'sd1);
      queue_load(6'd63, Q16_MAX);
      queue_matrix(Q16_MIN, '0);
      queue_matrix(Q16_MIN, '0);
      queue_matrix(Q16_MAX, '0);
      queue_matrix('0, '0);
      queue_matrix(Q16_MAX, '0);
      queue_matrix(Q16_MAX, '0);
      queue_matrix(Q16_MIN, '0);
      queue_matrix(Q16_MIN, ACC_MIN);
      repeat (3) queue_matrix('0, '0);
      queue_matrix('0, ACC_MAX);
      repeat (3) queue_matrix('0, '0);
      queue_matrix(Q16_MAX, ACC_MAX);
      // A row broken off by a load restarts the strip at the first row.
      queue_matrix(Q16_MAX, ACC_MIN);
      queue_matrix(Q16_MIN, ACC_MAX);
      queue_load(6'd3, 32'sd7);
      queue_matrix(Q16_MIN, ACC_MIN);
      repeat (3) queue_matrix('0, '0);
      // Leave the strip two words into a row.
      queue_matrix(Q16_MAX, '0);
      queue_matrix(Q16_MAX, '0);
      wait_idle();

      // Width lowered below the column position ends the open row at once.
      write_csrs(7'd1, 16'd10, 16'd1000);
      queue_matrix(Q16_MAX, ACC_MAX);
      queue_matrix(Q16_MIN, ACC_MIN);
      queue_matrix(pick_q16(), pick_q32());
      wait_idle();

      // Width zero acts as one; rows at and past the last 16-bit index are dropped.
      write_csrs(7'd0, 16'd65534, 16'd65535);
      queue_load(6'd5, pick_q16());
      repeat (3) queue_matrix(pick_q16(), pick_q32());
      wait_idle();

      // Width above the store size acts as the store size; end_row zero drops all.
      write_csrs(7'd127, 16'd65535, 16'd0);
      queue_load(6'd9, pick_q16());
      repeat (130) queue_matrix(pick_q16(), pick_q32());
      wait_idle();

      // A strip of single-word rows that runs past end_row, so the tail is dropped.
      write_csrs(7'd1, 16'd0, 16'd100);
      queue_load(6'd0, pick_q16());
      repeat (150) queue_matrix(pick_q16(), pick_q32());
      wait_idle();

      // Every matrix word finishes a row and every row is returned, while the
      // receiver holds off for a long stretch.
      write_csrs(7'd1, 16'd0, 16'd65535);
      queue_load(6'd0, pick_q16());
      queue_random_words(200, 1);
      hold_armed = 1'b1;
      wait_idle();

      for (mode = 0; mode < 4; mode++) begin
         for (sub = 0; sub < 2; sub++) begin
            case (mode)
               0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
               1: begin send_idle_pct = 71; rsp_stall_pct = 0;  end
               2: begin send_idle_pct = 0;  rsp_stall_pct = 71; end
               default: begin send_idle_pct = 7; rsp_stall_pct = 7; end
            endcase
            k = $urandom_range(0, 19);
            if (k < 2) w = STORE_DEPTH;
            else if (k < 3) w = 0;
            else if (k < 4) w = $urandom_range(STORE_DEPTH + 1, 127);
            else w = $urandom_range(1, 8);
            f = $urandom_range(0, 2000);
            k = $urandom_range(0, 19);
            if (k == 0) e = 0;
            else if (k == 1) e = 65535;
            else e = f + $urandom_range(0, 300);
            write_csrs(7'(w), 16'(f), 16'(e));
            queue_load(X_INDEX_W'($urandom_range(0, STORE_DEPTH - 1)), pick_q16());
            queue_random_words(180, eff_width(7'(w)));
            wait_idle();
         end
      end

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/sbm_pkg.sv
hdl/sbm_channels.sv
hdl/sbm_ctrl.sv
hdl/sbm_vstore.sv
hdl/sbm_datapath.sv
hdl/strided_block_matvec_accumulate_core.sv
verif/tb_top.sv
